>>> design/clr_pkg.sv
// Shared constants, codes and types for the checked linear resampler.
// Used by the channel interfaces, the mul/div unit and the top level.
package clr_pkg;

    // Table size and derived widths.
    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Field widths of the items.
    localparam int CMD_W   = 2;
    localparam int X_W     = 40;
    localparam int Y_W     = 48;
    localparam int ERR_W   = 47;
    localparam int LIMIT_W = 47;
    localparam int ST_W    = 3;

    // Arithmetic widths: differences carry one extra bit, the quotient is clamped to 2^50.
    localparam int DY_W  = Y_W + 1;
    localparam int DX_W  = X_W + 1;
    localparam int QUO_W = 51;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_EXACT     = 3'd0;
    localparam logic [ST_W-1:0] ST_INTERP    = 3'd1;
    localparam logic [ST_W-1:0] ST_OUT_RANGE = 3'd2;
    localparam logic [ST_W-1:0] ST_INVALID   = 3'd3;
    localparam logic [ST_W-1:0] ST_ZERO_INT  = 3'd4;

    // One stored sample point.
    typedef struct packed {
        logic [X_W-1:0]   x;
        logic [Y_W-1:0]   y;
        logic [ERR_W-1:0] err;
    } clr_entry_t;

    localparam int ENTRY_W = $bits(clr_entry_t);

    // Request to the multiply/divide unit.
    typedef struct packed {
        logic            start;
        logic [DY_W-1:0] mag_dy;
        logic [DX_W-1:0] mag_dq;
        logic [DX_W-1:0] mag_dx;
    } clr_div_req_t;

    // Response from the multiply/divide unit.
    typedef struct packed {
        logic             done;
        logic [QUO_W-1:0] quot;
    } clr_div_rsp_t;

endpackage

>>> design/clr_in_if.sv
// Input channel of the resampler: valid/ready handshake with the command item.
// Depends on clr_pkg for the field widths.
interface clr_in_if;
    import clr_pkg::*;

    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic [X_W-1:0]   point_x;
    logic [Y_W-1:0]   point_y;
    logic [ERR_W-1:0] point_err;

    modport source (output valid, output command, output point_x, output point_y,
                    output point_err, input ready);
    modport sink   (input valid, input command, input point_x, input point_y,
                    input point_err, output ready);
endinterface

>>> design/clr_out_if.sv
// Output channel of the resampler: valid/ready handshake with the result item.
// Depends on clr_pkg for the field widths.
interface clr_out_if;
    import clr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic signed [Y_W-1:0] value;
    logic [ST_W-1:0]       status;

    modport source (output valid, output value, output status, input ready);
    modport sink   (input valid, input value, input status, output ready);
endinterface

>>> design/clr_ram.sv
// Generic single-port RAM with one write and one registered read per cycle.
// Stands alone; width and depth come from its parameters.
module clr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read of the same address.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> design/clr_muldiv.sv
// Iterative multiply and rounded divide around one shared adder.
// Depends on clr_pkg for widths and the request/response structs.
module clr_muldiv (
    input  logic                  clk,
    input  logic                  rst_n,
    input  clr_pkg::clr_div_req_t req,
    output clr_pkg::clr_div_rsp_t rsp
);
    import clr_pkg::*;

    // Product is kept as {hi, lo}; lo starts as the multiplier.
    localparam int HI_W   = DY_W + 1;
    localparam int LO_W   = DX_W;
    localparam int SPLIT  = QUO_W - LO_W;
    localparam int REM_W  = DX_W;
    localparam int ADD_W  = QUO_W + 1;
    localparam int CNT_AW = $clog2(QUO_W + 1);

    localparam logic [2:0] A_IDLE = 3'd0;
    localparam logic [2:0] A_MUL  = 3'd1;
    localparam logic [2:0] A_OVF  = 3'd2;
    localparam logic [2:0] A_DIV  = 3'd3;
    localparam logic [2:0] A_RND  = 3'd4;
    localparam logic [2:0] A_INC  = 3'd5;

    localparam logic [QUO_W-1:0] CLAMP = {1'b1, {(QUO_W-1){1'b0}}};

    logic [2:0]        state_reg, state_next;
    logic [CNT_AW-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [HI_W-1:0]   hi_reg, hi_next;
    logic [LO_W-1:0]   lo_reg, lo_next;
    logic [DY_W-1:0]   mcand_reg, mcand_next;
    logic [DX_W-1:0]   dx_reg, dx_next;
    logic [REM_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  quo_reg, quo_next;
    logic              rnd_reg, rnd_next;
    logic [QUO_W-1:0]  quot_reg, quot_next;

    logic [ADD_W-1:0]  add_a, add_b, dx_inv;
    logic              add_cin;
    logic [ADD_W:0]    add_sum;
    logic              carry;
    logic [QUO_W:0]    q_inc;

    // The one shared adder; subtraction is done with the inverted divisor and a carry in.
    assign dx_inv  = ~ADD_W'(dx_reg);
    assign add_sum = {1'b0, add_a} + {1'b0, add_b} + {{ADD_W{1'b0}}, add_cin};
    assign carry   = add_sum[ADD_W];
    assign q_inc   = add_sum[QUO_W:0];

    // Operand selection for each step.
    always_comb
    begin
        add_a   = '0;
        add_b   = '0;
        add_cin = 1'b0;
        unique case (state_reg)
            A_MUL:
            begin
                add_a = ADD_W'(hi_reg);
                add_b = lo_reg[0] ? ADD_W'(mcand_reg) : '0;
            end
            A_OVF:
            begin
                add_a   = ADD_W'(hi_reg[HI_W-1:SPLIT]);
                add_b   = dx_inv;
                add_cin = 1'b1;
            end
            A_DIV:
            begin
                add_a   = ADD_W'({rem_reg, quo_reg[QUO_W-1]});
                add_b   = dx_inv;
                add_cin = 1'b1;
            end
            A_RND:
            begin
                add_a   = ADD_W'({rem_reg, 1'b0});
                add_b   = dx_inv;
                add_cin = 1'b1;
            end
            A_INC:
            begin
                add_a   = ADD_W'(quo_reg);
                add_cin = rnd_reg;
            end
            default:
            begin
                add_a = '0;
            end
        endcase
    end

    // Sequencer: shift-add multiply, overflow check, restoring divide, rounding.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        mcand_next = mcand_reg;
        dx_next    = dx_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        rnd_next   = rnd_reg;
        quot_next  = quot_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (req.start)
                begin
                    hi_next    = '0;
                    lo_next    = req.mag_dq;
                    mcand_next = req.mag_dy;
                    dx_next    = req.mag_dx;
                    cnt_next   = CNT_AW'(LO_W);
                    state_next = A_MUL;
                end
            end
            A_MUL:
            begin
                hi_next  = {1'b0, add_sum[HI_W-1:1]};
                lo_next  = {add_sum[0], lo_reg[LO_W-1:1]};
                cnt_next = cnt_reg - CNT_AW'(1);
                if (cnt_reg == CNT_AW'(1))
                begin
                    state_next = A_OVF;
                end
            end
            A_OVF:
            begin
                // A quotient of 2^51 or more is clamped without dividing.
                if (carry)
                begin
                    quot_next  = CLAMP;
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
                else
                begin
                    rem_next   = REM_W'(hi_reg[HI_W-1:SPLIT]);
                    quo_next   = {hi_reg[SPLIT-1:0], lo_reg};
                    cnt_next   = CNT_AW'(QUO_W);
                    state_next = A_DIV;
                end
            end
            A_DIV:
            begin
                if (carry)
                begin
                    rem_next = add_sum[REM_W-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[REM_W-2:0], quo_reg[QUO_W-1]};
                end
                quo_next = {quo_reg[QUO_W-2:0], carry};
                cnt_next = cnt_reg - CNT_AW'(1);
                if (cnt_reg == CNT_AW'(1))
                begin
                    state_next = A_RND;
                end
            end
            A_RND:
            begin
                // Round half away: twice the remainder against the divisor.
                rnd_next   = carry;
                state_next = A_INC;
            end
            A_INC:
            begin
                if (q_inc > {1'b0, CLAMP})
                begin
                    quot_next = CLAMP;
                end
                else
                begin
                    quot_next = q_inc[QUO_W-1:0];
                end
                done_next  = 1'b1;
                state_next = A_IDLE;
            end
            default:
            begin
                state_next = A_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        mcand_reg <= mcand_next;
        dx_reg    <= dx_next;
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        rnd_reg   <= rnd_next;
        quot_reg  <= quot_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

>>> design/checked_linear_resampler_top.sv
// Top level of the checked linear resampler: point table, query sequencer, output register.
// Depends on clr_pkg, clr_in_if, clr_out_if, clr_ram and clr_muldiv.
//
// The block keeps a table of up to TABLE_DEPTH sample points (abscissa, value, error).
// Points must be appended, and queries given, in descending abscissa order; the block
// does not enforce this. It answers queries with a search pointer that only moves forward.
// Append, clear and unknown commands give no result. A query walks the pointer over every
// table point at or above it, with one RAM read and one compare for each, ends the walk,
// then fetches the bracketing points and checks them; an out-of-range query, an exact
// match or a rejected interval finishes there. A real interpolation then waits on the
// shared adder of the multiply/divide unit: 41 multiply steps, one overflow check, 51
// divide steps and two rounding steps, the last of which adds and saturates. A quotient
// that overflows is clamped right after the overflow check. The result is then handed
// to the output register once that register no longer holds an earlier result. The
// result sits in the output register, so the next item is taken while the previous
// result waits to be collected. Table entries are held in a single-port RAM with
// registered read; that one port sets the pace of the pointer walk, one read and one
// compare for each point. The table contents are not cleared by reset or by the clear
// command; only the point count and the pointer are.
module checked_linear_resampler_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         invalid_limit_we,
    input  logic [clr_pkg::LIMIT_W-1:0]  invalid_limit_wdata,
    clr_in_if.sink                       in_item,
    clr_out_if.source                    out_item
);
    import clr_pkg::*;

    localparam int SUM_W = QUO_W + 2;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_WALK_RD  = 4'd1;
    localparam logic [3:0] S_WALK_CHK = 4'd2;
    localparam logic [3:0] S_P0_RD    = 4'd3;
    localparam logic [3:0] S_P0_CHK   = 4'd4;
    localparam logic [3:0] S_P1_CHK   = 4'd5;
    localparam logic [3:0] S_PREP     = 4'd6;
    localparam logic [3:0] S_WAIT     = 4'd7;
    localparam logic [3:0] S_FIN      = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   ptr_reg, ptr_next;
    logic [CNT_W-1:0]   ptr_m1;
    logic [LIMIT_W-1:0] limit_reg;
    logic               out_valid_reg, out_valid_next;
    logic [Y_W-1:0]     out_value_reg, out_value_next;
    logic [ST_W-1:0]    out_status_reg, out_status_next;

    logic [X_W-1:0]     q_reg, q_next;
    logic [X_W-1:0]     x0_reg, x0_next, x1_reg, x1_next;
    logic [Y_W-1:0]     y0_reg, y0_next, y1_reg, y1_next;
    logic [ERR_W-1:0]   e0_reg, e0_next, e1_reg, e1_next;
    logic               neg_reg, neg_next;
    logic [Y_W-1:0]     res_val_reg, res_val_next;
    logic [ST_W-1:0]    res_st_reg, res_st_next;

    clr_div_req_t       div_req_reg, div_req_next;
    clr_div_rsp_t       div_rsp;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_addr;
    logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
    clr_entry_t         rd_entry, wr_entry;

    logic               in_accept;
    logic [Y_W-1:0]     mag0, mag1;
    logic               bad_point;
    logic [DX_W-1:0]    dx, dq;
    logic [DY_W-1:0]    dy;
    logic [DX_W-1:0]    mag_dx, mag_dq;
    logic [DY_W-1:0]    mag_dy;
    logic [SUM_W-1:0]   y0_ext, t_ext, sum;
    logic               sum_fits;
    logic [Y_W-1:0]     sat_val;

    // Point table storage.
    assign wr_entry.x   = in_item.point_x;
    assign wr_entry.y   = in_item.point_y;
    assign wr_entry.err = in_item.point_err;
    assign ram_wdata    = wr_entry;
    assign rd_entry     = clr_entry_t'(ram_rdata);

    clr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Multiply/divide unit.
    clr_muldiv u_muldiv (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req_reg),
        .rsp   (div_rsp)
    );

    assign in_item.ready  = (state_reg == S_IDLE);
    assign in_accept      = in_item.valid && in_item.ready;
    assign out_item.valid = out_valid_reg;
    assign out_item.value = out_value_reg;
    assign out_item.status = out_status_reg;
    assign ptr_m1         = ptr_reg - CNT_W'(1);

    // Validity checks and differences of the bracketing points.
    always_comb
    begin
        mag0      = y0_reg[Y_W-1] ? (~y0_reg + Y_W'(1)) : y0_reg;
        mag1      = y1_reg[Y_W-1] ? (~y1_reg + Y_W'(1)) : y1_reg;
        bad_point = (mag0 > {1'b0, limit_reg}) || (mag1 > {1'b0, limit_reg}) ||
                    ({1'b0, e0_reg} >= mag0) || ({1'b0, e1_reg} >= mag1);
        dx        = {1'b0, x1_reg} - {1'b0, x0_reg};
        dq        = {1'b0, q_reg} - {1'b0, x0_reg};
        dy        = {y1_reg[Y_W-1], y1_reg} - {y0_reg[Y_W-1], y0_reg};
        mag_dx    = dx[DX_W-1] ? (~dx + DX_W'(1)) : dx;
        mag_dq    = dq[DX_W-1] ? (~dq + DX_W'(1)) : dq;
        mag_dy    = dy[DY_W-1] ? (~dy + DY_W'(1)) : dy;
    end

    // Signed correction added to the left point, saturated to the value range.
    always_comb
    begin
        y0_ext   = {{(SUM_W-Y_W){y0_reg[Y_W-1]}}, y0_reg};
        t_ext    = SUM_W'(div_rsp.quot);
        sum      = neg_reg ? (y0_ext - t_ext) : (y0_ext + t_ext);
        sum_fits = (&sum[SUM_W-1:Y_W-1]) || !(|sum[SUM_W-1:Y_W-1]);
        if (sum_fits)
        begin
            sat_val = sum[Y_W-1:0];
        end
        else if (sum[SUM_W-1])
        begin
            sat_val = {1'b1, {(Y_W-1){1'b0}}};
        end
        else
        begin
            sat_val = {1'b0, {(Y_W-1){1'b1}}};
        end
    end

    // Query sequencer and table control.
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        ptr_next        = ptr_reg;
        q_next          = q_reg;
        x0_next         = x0_reg;
        y0_next         = y0_reg;
        e0_next         = e0_reg;
        x1_next         = x1_reg;
        y1_next         = y1_reg;
        e1_next         = e1_reg;
        neg_next        = neg_reg;
        res_val_next    = res_val_reg;
        res_st_next     = res_st_reg;
        div_req_next    = div_req_reg;
        div_req_next.start = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = ptr_reg[ADDR_W-1:0];
        out_valid_next  = out_valid_reg && !out_item.ready;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    unique case (in_item.command)
                        CMD_APPEND:
                        begin
                            if (count_reg < CNT_W'(TABLE_DEPTH))
                            begin
                                ram_we     = 1'b1;
                                ram_addr   = count_reg[ADDR_W-1:0];
                                count_next = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                            ptr_next   = '0;
                        end
                        CMD_QUERY:
                        begin
                            q_next = in_item.point_x;
                            if (count_reg == '0)
                            begin
                                res_val_next = '0;
                                res_st_next  = ST_OUT_RANGE;
                                state_next   = S_FIN;
                            end
                            else
                            begin
                                state_next = S_WALK_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_WALK_RD:
            begin
                // Fetch the point under the pointer while any remain.
                if (ptr_reg < count_reg)
                begin
                    state_next = S_WALK_CHK;
                end
                else
                begin
                    state_next = S_P0_RD;
                end
            end
            S_WALK_CHK:
            begin
                // Skip every point at or above the query.
                if (rd_entry.x >= q_reg)
                begin
                    ptr_next   = ptr_reg + CNT_W'(1);
                    state_next = S_WALK_RD;
                end
                else
                begin
                    state_next = S_P0_RD;
                end
            end
            S_P0_RD:
            begin
                if (ptr_reg == '0)
                begin
                    res_val_next = '0;
                    res_st_next  = ST_OUT_RANGE;
                    state_next   = S_FIN;
                end
                else
                begin
                    ram_addr   = ptr_m1[ADDR_W-1:0];
                    state_next = S_P0_CHK;
                end
            end
            S_P0_CHK:
            begin
                x0_next = rd_entry.x;
                y0_next = rd_entry.y;
                e0_next = rd_entry.err;
                if (rd_entry.x == q_reg)
                begin
                    res_val_next = rd_entry.y;
                    res_st_next  = ST_EXACT;
                    state_next   = S_FIN;
                end
                else if (ptr_reg >= count_reg)
                begin
                    res_val_next = '0;
                    res_st_next  = ST_OUT_RANGE;
                    state_next   = S_FIN;
                end
                else
                begin
                    state_next = S_P1_CHK;
                end
            end
            S_P1_CHK:
            begin
                x1_next    = rd_entry.x;
                y1_next    = rd_entry.y;
                e1_next    = rd_entry.err;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                // Invalid or noisy points are rejected before a zero-width interval.
                if (bad_point)
                begin
                    res_val_next = '0;
                    res_st_next  = ST_INVALID;
                    state_next   = S_FIN;
                end
                else if (dx == '0)
                begin
                    res_val_next = '0;
                    res_st_next  = ST_ZERO_INT;
                    state_next   = S_FIN;
                end
                else
                begin
                    div_req_next.start  = 1'b1;
                    div_req_next.mag_dy = mag_dy;
                    div_req_next.mag_dq = mag_dq;
                    div_req_next.mag_dx = mag_dx;
                    neg_next   = dy[DY_W-1] ^ dq[DX_W-1] ^ dx[DX_W-1];
                    state_next = S_WAIT;
                end
            end
            S_WAIT:
            begin
                if (div_rsp.done)
                begin
                    res_val_next = sat_val;
                    res_st_next  = ST_INTERP;
                    state_next   = S_FIN;
                end
            end
            S_FIN:
            begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || out_item.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_val_reg;
                    out_status_next = res_st_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= S_IDLE;
            count_reg          <= '0;
            ptr_reg            <= '0;
            limit_reg          <= '1;
            out_valid_reg      <= 1'b0;
            div_req_reg        <= '0;
        end
        else
        begin
            state_reg          <= state_next;
            count_reg          <= count_next;
            ptr_reg            <= ptr_next;
            out_valid_reg      <= out_valid_next;
            div_req_reg        <= div_req_next;
            if (invalid_limit_we)
            begin
                limit_reg <= invalid_limit_wdata;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        q_reg              <= q_next;
        x0_reg             <= x0_next;
        y0_reg             <= y0_next;
        e0_reg             <= e0_next;
        x1_reg             <= x1_next;
        y1_reg             <= y1_next;
        e1_reg             <= e1_next;
        neg_reg            <= neg_next;
        res_val_reg        <= res_val_next;
        res_st_reg         <= res_st_next;
        out_value_reg      <= out_value_next;
        out_status_reg     <= out_status_next;
    end

    // The search pointer never passes the number of stored points.
    assert property (@(posedge clk) disable iff (!rst_n) ptr_reg <= count_reg)
        else $error("search pointer beyond point count");

    // The divider only answers while the sequencer waits for it.
    assert property (@(posedge clk) disable iff (!rst_n) div_rsp.done |-> state_reg == S_WAIT)
        else $error("divider result outside of wait state");

    // A query blocks further items in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_item.command == CMD_QUERY) |=> !in_item.ready)
        else $error("input accepted while a query is in progress");

    // A delivered status is always one of the defined codes.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_status_reg <= ST_ZERO_INT)
        else $error("undefined status code on output");

endmodule
